/* design/rfpbs_pkg.sv */
// rfpbs_pkg: shared types, constants and helper functions for the packet byte scrambler
// no dependencies; imported by rf_packet_byte_scrambler

package rfpbs_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] pos_t;

    // one result item as held in the output and skid stages
    typedef struct packed {
        byte_t data;
        logic  last;
    } result_t;

    localparam pos_t  POS_KEY    = 4'd0;
    localparam pos_t  POS_LAST   = 4'd8;
    localparam byte_t JUMP_BUMP  = 8'h80;
    localparam byte_t CHECK_ADD  = 8'h02;
    localparam logic  DIR_ENCODE = 1'b0;

    // constant offset table, row = packet position minus one, column = key low bits
    function automatic byte_t offset_lookup(input logic [2:0] row, input logic [1:0] col);
        byte_t val;
        begin
            case ({row, col})
                5'd0:    val = 8'h45;
                5'd1:    val = 8'h1F;
                5'd2:    val = 8'h14;
                5'd3:    val = 8'h5C;
                5'd4:    val = 8'h2B;
                5'd5:    val = 8'hC9;
                5'd6:    val = 8'hE3;
                5'd7:    val = 8'h11;
                5'd8:    val = 8'h6D;
                5'd9:    val = 8'h5F;
                5'd10:   val = 8'h8A;
                5'd11:   val = 8'h2B;
                5'd12:   val = 8'hAF;
                5'd13:   val = 8'h03;
                5'd14:   val = 8'h1D;
                5'd15:   val = 8'hF3;
                5'd16:   val = 8'h1A;
                5'd17:   val = 8'hE2;
                5'd18:   val = 8'hF0;
                5'd19:   val = 8'hD1;
                5'd20:   val = 8'h04;
                5'd21:   val = 8'hD8;
                5'd22:   val = 8'h71;
                5'd23:   val = 8'h42;
                5'd24:   val = 8'hAF;
                5'd25:   val = 8'h04;
                5'd26:   val = 8'hDD;
                5'd27:   val = 8'h07;
                5'd28:   val = 8'h61;
                5'd29:   val = 8'h13;
                5'd30:   val = 8'h38;
                5'd31:   val = 8'h64;
                default: val = 8'h00;
            endcase
            return val;
        end
    endfunction

    // nibble-wise mixing key derived from the key byte
    function automatic byte_t derive_mix(input byte_t k);
        logic       bump;
        logic [2:0] x;
        logic [3:0] hi_n;
        logic [3:0] lo_n;
        begin
            bump = (k[3:0] >= 4'h4);
            x    = k[6:4] + {2'b00, bump} + 3'd6;
            hi_n = (4'd4 + {1'b0, x}) ^ 4'h1;
            lo_n = (k[3:0] + 4'd4) ^ 4'h2;
            return {hi_n, lo_n};
        end
    endfunction

endpackage

/* design/rf_packet_byte_scrambler.sv */
// rf_packet_byte_scrambler: 9-byte radio packet scrambler / unscrambler, one byte per item
// depends on rfpbs_pkg for the offset table, mixing key function and result type
//
// a result reaches out_valid in the cycle after input accept when the output stage is free
// throughput: one item per cycle; a one-item skid stage behind the output register
//   lets the block take an item while a result waits, in_stall rises only when both are full
// reset: rst_n asynchronous active low clears packet state, jump_start and both valid flags

module rf_packet_byte_scrambler
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  rfpbs_pkg::byte_t   cfg_data,
    // input item channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic               start_req,
    input  rfpbs_pkg::byte_t   data_in,
    // result item channel
    output logic               out_valid,
    input  logic               out_stall,
    output rfpbs_pkg::byte_t   data_out,
    output logic               last
);

    import rfpbs_pkg::*;

    byte_t   jump_start_reg;
    byte_t   key_byte_reg,  key_byte_next;
    byte_t   mix_key_reg,   mix_key_next;
    pos_t    position_reg,  position_next;
    byte_t   run_sum_reg,   run_sum_next;
    logic    direction_reg, direction_next;

    result_t out_reg,  skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    result_t result_new;

    logic    in_fire;
    logic    out_fire;
    logic    is_key;
    logic    jump_hit;
    byte_t   off_base;
    byte_t   off_jump;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign data_out  = out_reg.data;
    assign last      = out_reg.last;

    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_start_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            jump_start_reg <= cfg_data;
        end
    end

    // offset selection with optional jump window bump
    always_comb
    begin
        off_base = offset_lookup(position_reg[2:0] - 3'd1, key_byte_reg[1:0]);
        jump_hit = (jump_start_reg != 8'h00)
                && (key_byte_reg >= jump_start_reg)
                && ({1'b0, key_byte_reg} < ({1'b0, jump_start_reg} + {1'b0, JUMP_BUMP}));
        off_jump = jump_hit ? (off_base + JUMP_BUMP) : off_base;
    end

    // per-byte transform and packet state update
    always_comb
    begin
        is_key         = start_req || (position_reg == POS_KEY) || (position_reg > POS_LAST);
        key_byte_next  = key_byte_reg;
        mix_key_next   = mix_key_reg;
        run_sum_next   = run_sum_reg;
        direction_next = direction_reg;
        position_next  = position_reg;
        result_new     = '{data: data_in, last: 1'b0};
        if (is_key)
        begin
            direction_next = kind;
            key_byte_next  = data_in;
            mix_key_next   = derive_mix(data_in);
            run_sum_next   = derive_mix(data_in);
            position_next  = 4'd1;
        end
        else
        begin
            if (direction_reg == DIR_ENCODE)
            begin
                if (position_reg == POS_LAST)
                begin
                    result_new.data = ((run_sum_reg + CHECK_ADD) ^ mix_key_reg) + off_base;
                end
                else
                begin
                    run_sum_next    = run_sum_reg + data_in;
                    result_new.data = (data_in ^ mix_key_reg) + off_jump;
                end
            end
            else
            begin
                result_new.data = (data_in - off_jump) ^ mix_key_reg;
            end
            if (position_reg == POS_LAST)
            begin
                result_new.last = 1'b1;
                position_next   = POS_KEY;
            end
            else
            begin
                position_next = position_reg + 4'd1;
            end
        end
    end

    // packet state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_byte_reg  <= '0;
            mix_key_reg   <= '0;
            position_reg  <= POS_KEY;
            run_sum_reg   <= '0;
            direction_reg <= DIR_ENCODE;
        end
        else if (in_fire)
        begin
            key_byte_reg  <= key_byte_next;
            mix_key_reg   <= mix_key_next;
            position_reg  <= position_next;
            run_sum_reg   <= run_sum_next;
            direction_reg <= direction_next;
        end
    end

    // output stage and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output stage and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= result_new;
            end
            else
            begin
                out_reg <= result_new;
            end
        end
    end

endmodule

/* design/rfpbs_checker.sv */
// rfpbs_checker: port-level assertions for rf_packet_byte_scrambler, with its bind
// depends on rfpbs_pkg for the byte type; attaches to the top level by name

module rfpbs_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               start_req,
    input rfpbs_pkg::byte_t   data_in,
    input logic               out_valid,
    input logic               out_stall,
    input rfpbs_pkg::byte_t   data_out,
    input logic               last
);

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(last))
        else $error("stalled result changed");

    // input stalls only while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // the skid fills only when the output was held back
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall without output stall");

    // a key item into an empty output comes out next cycle unchanged, not last
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid && start_req
        |=> out_valid && (data_out == $past(data_in)) && !last)
        else $error("key byte not passed through");

endmodule

bind rf_packet_byte_scrambler rfpbs_checker u_rfpbs_checker (.*);

/* tb/sv/rf_packet_byte_scrambler_test.sv */
// rf_packet_byte_scrambler_test: self-checking testbench for the packet byte scrambler
// drives directed and random packets through several jump_start settings and checks every byte
// depends on rfpbs_pkg and rf_packet_byte_scrambler only
`timescale 1ns / 1ps

module rf_packet_byte_scrambler_test;

    import rfpbs_pkg::*;

    localparam logic DIR_DECODE = 1'b1;

    // offset table, index = (position - 1) * 4 + key low bits
    localparam byte_t SCRAMBLE_OFFSETS [32] = '{
        8'h45, 8'h1F, 8'h14, 8'h5C,
        8'h2B, 8'hC9, 8'hE3, 8'h11,
        8'h6D, 8'h5F, 8'h8A, 8'h2B,
        8'hAF, 8'h03, 8'h1D, 8'hF3,
        8'h1A, 8'hE2, 8'hF0, 8'hD1,
        8'h04, 8'hD8, 8'h71, 8'h42,
        8'hAF, 8'h04, 8'hDD, 8'h07,
        8'h61, 8'h13, 8'h38, 8'h64
    };

    localparam int PHASE_ITEMS = 120;

    // expected scrambler output bytes, computed from accepted input items
    class packet_scramble_board;
        byte_t   jump_start;
        byte_t   key_byte;
        byte_t   mix_key;
        byte_t   running_sum;
        int      position;
        logic    direction;
        result_t expected_bytes [$];
        int      mismatch_count;

        function new();
            jump_start     = 8'h00;
            key_byte       = 8'h00;
            mix_key        = 8'h00;
            running_sum    = 8'h00;
            position       = 0;
            direction      = DIR_ENCODE;
            mismatch_count = 0;
        endfunction

        function void set_jump(byte_t v);
            jump_start = v;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // mixing key: high nibble from key bits 6:4, low nibble from key bits 3:0
        function byte_t mix_of(byte_t k);
            int lo;
            int x;
            int hi_n;
            int lo_n;
            lo   = int'(k[3:0]);
            x    = (int'(k[7:4]) + ((lo < 4) ? 0 : 1) + 6) & 7;
            hi_n = ((4 + x) ^ 1) & 15;
            lo_n = ((lo + 4) ^ 2) & 15;
            return byte_t'((hi_n << 4) | lo_n);
        endfunction

        function byte_t offset_of(int pos, bit allow_jump);
            byte_t off;
            off = SCRAMBLE_OFFSETS[((pos - 1) & 7) * 4 + int'(key_byte[1:0])];
            if (allow_jump && jump_start != 8'h00 && key_byte >= jump_start &&
                int'(key_byte) < int'(jump_start) + 128)
                off = off + JUMP_BUMP;
            return off;
        endfunction

        // one accepted input byte gives one expected output byte
        function void note_byte(logic k, logic s, byte_t b);
            result_t r;
            r.last = 1'b0;
            if (s || position == 0 || position > 8)
            begin
                direction   = k;
                key_byte    = b;
                mix_key     = mix_of(b);
                running_sum = mix_key;
                r.data      = b;
                position    = 1;
            end
            else
            begin
                if (direction == DIR_ENCODE)
                begin
                    if (position == 8)
                        r.data = ((running_sum + CHECK_ADD) ^ mix_key) + offset_of(position, 1'b0);
                    else
                    begin
                        running_sum = running_sum + b;
                        r.data      = (b ^ mix_key) + offset_of(position, 1'b1);
                    end
                end
                else
                    r.data = (b - offset_of(position, 1'b1)) ^ mix_key;
                if (position == 8)
                begin
                    r.last   = 1'b1;
                    position = 0;
                end
                else
                    position = position + 1;
            end
            expected_bytes.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_byte(byte_t d, logic l);
            result_t r;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item data_out=%02h last=%0b", d, l));
                return;
            end
            r = expected_bytes.pop_front();
            if (d !== r.data)
                report_mismatch($sformatf("data_out=%02h expected %02h", d, r.data));
            if (l !== r.last)
                report_mismatch($sformatf("last=%0b expected %0b", l, r.last));
        endtask
    endclass

    logic  clk;
    logic  rst_n;
    logic  cfg_valid;
    logic  cfg_ready;
    byte_t cfg_data;
    logic  in_valid;
    logic  in_stall;
    logic  kind;
    logic  start_req;
    byte_t data_in;
    logic  out_valid;
    logic  out_stall;
    byte_t data_out;
    logic  last;

    packet_scramble_board sb;
    bit quiet;
    bit aligned;
    int items_sent;

    rf_packet_byte_scrambler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .start_req (start_req),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // handshake monitor: config writes, accepted input items, accepted result items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_jump(cfg_data);
            if (in_valid && !in_stall)
                sb.note_byte(kind, start_req, data_in);
            if (out_valid && !out_stall)
                sb.check_byte(data_out, last);
        end
    end

    // receiver backpressure in random bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && rst_n && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic byte_t random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    // present one item, optionally after a sender gap, and hold it until accepted
    task automatic send_item(logic k, logic s, byte_t d);
        begin
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            in_valid  <= 1'b1;
            kind      <= k;
            start_req <= s;
            data_in   <= d;
            do @(posedge clk); while (in_stall);
            @(negedge clk);
            items_sent++;
        end
    endtask

    // register write once all results are back
    task automatic write_jump(byte_t v);
        begin
            in_valid <= 1'b0;
            while (sb.pending() != 0) @(negedge clk);
            repeat (2) @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= v;
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // a packet with a key mostly near the jump window edges; one in ten is cut short
    task automatic send_packet(byte_t jump);
        logic  k;
        logic  s;
        byte_t key;
        int    len;
        begin
            k = logic'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0:       key = jump - 8'd1;
                1:       key = jump;
                2:       key = jump + 8'h7F;
                3:       key = jump + 8'h80;
                default: key = random_byte();
            endcase
            s   = aligned ? logic'($urandom_range(0, 1)) : 1'b1;
            len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 8)) : 9;
            send_item(k, s, key);
            for (int i = 1; i < len; i++)
                send_item(logic'($urandom_range(0, 1)), 1'b0, random_byte());
            aligned = (len == 9);
        end
    endtask

    task automatic run_phase(byte_t jump);
        int target;
        begin
            write_jump(jump);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                send_packet(jump);
            in_valid <= 1'b0;
        end
    endtask

    initial
    begin
        sb         = new();
        quiet      = 1'b0;
        aligned    = 1'b1;
        items_sent = 0;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = 8'h00;
        in_valid   = 1'b0;
        kind       = DIR_ENCODE;
        start_req  = 1'b0;
        data_in    = 8'h00;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // encode packet with key zero and extreme data, checksum replaces byte 8
        send_item(DIR_ENCODE, 1'b1, 8'h00);
        for (int i = 1; i < 9; i++)
            send_item(DIR_ENCODE, 1'b0, (i % 2) ? 8'hFF : 8'h00);
        // wrap into a decode packet without a start request, byte 8 decoded unchecked
        send_item(DIR_DECODE, 1'b0, 8'hFF);
        for (int i = 1; i < 9; i++)
            send_item(DIR_ENCODE, 1'b0, (i % 2) ? 8'h00 : 8'hFF);
        // start request mid-packet abandons the partial packet
        send_item(DIR_ENCODE, 1'b1, 8'h37);
        send_item(DIR_DECODE, 1'b0, 8'h5A);
        send_item(DIR_ENCODE, 1'b0, 8'hA5);
        send_item(DIR_DECODE, 1'b1, 8'h03);
        send_item(DIR_ENCODE, 1'b0, 8'h80);
        send_item(DIR_DECODE, 1'b0, 8'h7F);
        in_valid <= 1'b0;
        aligned = 1'b0;

        // jump window settings, including a window that runs past 0xFF
        run_phase(8'h01);
        run_phase(8'hFF);
        run_phase(8'h80);
        run_phase(8'hC0);
        run_phase(byte_t'($urandom_range(1, 255)));
        run_phase(8'h00);
        quiet = 1'b1;
        run_phase(byte_t'($urandom_range(0, 255)));

        // drain and let the output stage settle
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
design/rfpbs_pkg.sv
design/rf_packet_byte_scrambler.sv
design/rfpbs_checker.sv
tb/sv/rf_packet_byte_scrambler_test.sv
